>>> sv/sle_pkg.sv
// ---------------------------------------------------------------------------
// Sequential list engine package
// Shared constants, command codes and the per-cell action type.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 4;
   localparam int POS_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int FIDX_W    = 8;
   localparam int COUNT_W   = 9;

   localparam logic [MODE_W-1:0] MODE_PUSH_BACK    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_POP_BACK     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_ERASE        = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FIND         = 4'd6;
   localparam logic [MODE_W-1:0] MODE_MODIFY       = 4'd7;
   localparam logic [MODE_W-1:0] MODE_REMOVE_FIRST = 4'd8;
   localparam logic [MODE_W-1:0] MODE_REMOVE_ALL   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_SORT         = 4'd10;
   localparam logic [MODE_W-1:0] MODE_BSEARCH      = 4'd11;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_LOAD,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_SORT_LO,
      ACT_SORT_HI
   } cell_act_type;

   typedef struct packed {
      logic load_en;
      logic up_en;
      logic dn_en;
      logic sort_en;
      logic phase;
   } chain_ctl_type;

endpackage

>>> sv/sle_cell.sv
// ---------------------------------------------------------------------------
// List cell
// Holds one entry, moves data to or from its neighbors and compares its
// entry with the search value.
// ---------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
   input  logic                     clock,
   input  cell_act_type             act,
   input  logic signed [DATA_W-1:0] load_value,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     eq,
   output logic                     lt
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (act)
         ACT_HOLD:    data_in = data_ff;
         ACT_LOAD:    data_in = load_value;
         ACT_LEFT:    data_in = left_data;
         ACT_RIGHT:   data_in = right_data;
         ACT_SORT_LO: if (right_data < data_ff) data_in = right_data;
         ACT_SORT_HI: if (data_ff < left_data) data_in = left_data;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign eq   = (data_ff == load_value);
   assign lt   = (data_ff < load_value);

endmodule

>>> sv/sequential_list_engine.sv
// ---------------------------------------------------------------------------
// Sequential list engine
// Packed list of signed 32-bit entries held in a chain of cells.
// ---------------------------------------------------------------------------
// One command is taken at a time and answered with one result. Push front,
// pop front, insert and erase shift the chain at once; push back and modify
// load one cell and pop back only lowers the count. The next request can
// transfer in the cycle after the result transfer. Find and remove first
// walk a pointer along the cells, one cell per cycle, up to the live count.
// Remove all walks the pointer too, closing the gap at each match. Sort runs
// odd-even exchange rounds between neighboring cells, one round per cycle,
// live count rounds in all. Binary search takes one halving step per cycle.
// The entry store needs no clearing after reset.
module sequential_list_engine import sle_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [DATA_W-1:0]   req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WALK = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic                     phase_ff, phase_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     found_ff, found_in;
   logic [FIDX_W-1:0]        fidx_ff, fidx_in;

   chain_ctl_type            ctl;
   logic [CMP_W-1:0]         ctl_at;

   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         eq_vec;
   logic [DEPTH-1:0]         lt_vec;
   logic [DEPTH-1:0]         lo_sel;

   logic [CMP_W-1:0]         cnt_ext;
   logic [CMP_W-1:0]         pos_ext;
   logic [CNT_W-1:0]         mid;
   logic                     full;

   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(pos_ff);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign mid     = ptr_ff + ((hi_ff - ptr_ff) >> 1);

   // Cell chain with per-cell action decode.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
      cell_act_type             act;
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      logic                     hi_sel;

      assign lo_sel[i] = ctl.sort_en && (IDX[0] == ctl.phase) && ((IDX + 1'b1) < cnt_ext);

      if (i == 0) begin : g_first
         assign left_d = value_ff;
         assign hi_sel = 1'b0;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
         assign hi_sel = lo_sel[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end

      always_comb begin
         act = ACT_HOLD;
         if (ctl.load_en && IDX == ctl_at) begin
            act = ACT_LOAD;
         end else if (ctl.up_en && IDX > ctl_at) begin
            act = ACT_LEFT;
         end else if (ctl.dn_en && IDX >= ctl_at) begin
            act = ACT_RIGHT;
         end else if (lo_sel[i]) begin
            act = ACT_SORT_LO;
         end else if (hi_sel) begin
            act = ACT_SORT_HI;
         end
      end

      sle_cell u_cell (
         .clock      (clock),
         .act        (act),
         .load_value (value_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .eq         (eq_vec[i]),
         .lt         (lt_vec[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      hi_in     = hi_ff;
      phase_in  = phase_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fidx_in   = fidx_ff;
      ctl       = '0;
      ctl_at    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               value_in = req_value;
               pos_in   = req_position;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STAT_OK;
            found_in  = 1'b0;
            fidx_in   = '0;
            ptr_in    = '0;
            hi_in     = count_ff;
            phase_in  = 1'b0;
            state_in  = ST_RESP;
            case (mode_ff)
               MODE_PUSH_BACK: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     ctl.load_en = 1'b1;
                     ctl_at      = cnt_ext;
                     count_in    = count_ff + 1'b1;
                  end
               end
               MODE_PUSH_FRONT: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     ctl.load_en = 1'b1;
                     ctl.up_en   = 1'b1;
                     count_in    = count_ff + 1'b1;
                  end
               end
               MODE_INSERT: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else if (pos_ext > cnt_ext) begin
                     status_in = STAT_RANGE;
                  end else begin
                     ctl.load_en = 1'b1;
                     ctl.up_en   = 1'b1;
                     ctl_at      = pos_ext;
                     count_in    = count_ff + 1'b1;
                  end
               end
               MODE_POP_BACK: begin
                  if (count_ff == '0) status_in = STAT_EMPTY;
                  else count_in = count_ff - 1'b1;
               end
               MODE_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     ctl.dn_en = 1'b1;
                     count_in  = count_ff - 1'b1;
                  end
               end
               MODE_ERASE: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = STAT_RANGE;
                  end else begin
                     ctl.dn_en = 1'b1;
                     ctl_at    = pos_ext;
                     count_in  = count_ff - 1'b1;
                  end
               end
               MODE_MODIFY: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = STAT_RANGE;
                  end else begin
                     ctl.load_en = 1'b1;
                     ctl_at      = pos_ext;
                  end
               end
               MODE_FIND, MODE_REMOVE_FIRST, MODE_REMOVE_ALL, MODE_SORT, MODE_BSEARCH: begin
                  state_in = ST_WALK;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_WALK: begin
            case (mode_ff)
               MODE_FIND, MODE_REMOVE_FIRST: begin
                  if (ptr_ff >= count_ff) begin
                     state_in = ST_RESP;
                  end else if (eq_vec[ptr_ff[IDX_W-1:0]]) begin
                     found_in = 1'b1;
                     fidx_in  = FIDX_W'(ptr_ff);
                     state_in = ST_RESP;
                     if (mode_ff == MODE_REMOVE_FIRST) begin
                        ctl.dn_en = 1'b1;
                        ctl_at    = CMP_W'(ptr_ff);
                        count_in  = count_ff - 1'b1;
                     end
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
               MODE_REMOVE_ALL: begin
                  // A match closes the gap and the pointer stays put.
                  if (ptr_ff >= count_ff) begin
                     state_in = ST_RESP;
                  end else if (eq_vec[ptr_ff[IDX_W-1:0]]) begin
                     found_in  = 1'b1;
                     ctl.dn_en = 1'b1;
                     ctl_at    = CMP_W'(ptr_ff);
                     count_in  = count_ff - 1'b1;
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
               MODE_SORT: begin
                  // Odd-even exchange: count rounds leave the list sorted.
                  if (ptr_ff >= count_ff) begin
                     state_in = ST_RESP;
                  end else begin
                     ctl.sort_en = 1'b1;
                     ctl.phase   = phase_ff;
                     phase_in    = ~phase_ff;
                     ptr_in      = ptr_ff + 1'b1;
                  end
               end
               MODE_BSEARCH: begin
                  if (ptr_ff >= hi_ff) begin
                     state_in = ST_RESP;
                  end else if (eq_vec[mid[IDX_W-1:0]]) begin
                     found_in = 1'b1;
                     fidx_in  = FIDX_W'(mid);
                     state_in = ST_RESP;
                  end else if (lt_vec[mid[IDX_W-1:0]]) begin
                     ptr_in = mid + 1'b1;
                  end else begin
                     hi_in = mid;
                  end
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      hi_ff     <= hi_in;
      phase_ff  <= phase_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fidx_ff   <= fidx_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("live count exceeds list depth");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |=> $stable(count_ff))
      else $error("live count changed outside command execution");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted command did not start execution");

   a_walk_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (mode_ff == MODE_FIND || mode_ff == MODE_REMOVE_FIRST ||
         mode_ff == MODE_REMOVE_ALL || mode_ff == MODE_SORT || mode_ff == MODE_BSEARCH))
      else $error("walk entered for a single-cycle command");
`endif

endmodule
